### sv/netsplit_message_detector_core_defines.svh
// assertion macros for the netsplit message detector
// used by the rtl file that carries concurrent checks, needs i_clk and i_rst_n in scope
`ifndef NETSPLIT_MESSAGE_DETECTOR_CORE_DEFINES_SVH
`define NETSPLIT_MESSAGE_DETECTOR_CORE_DEFINES_SVH

// same-cycle implication, checked outside reset
`define NMD_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("nmd check failed");

// next-cycle implication, checked outside reset
`define NMD_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("nmd check failed");

`endif

### sv/nmd_pkg.sv
// shared types and character constants for the netsplit message detector
// no dependencies
package nmd_pkg;

    localparam logic [7:0] CH_DOT   = 8'h2E;
    localparam logic [7:0] CH_DASH  = 8'h2D;
    localparam logic [7:0] CH_STAR  = 8'h2A;
    localparam logic [7:0] CH_BLANK = 8'h20;
    localparam logic [7:0] CH_DIG_LO = 8'h30;
    localparam logic [7:0] CH_DIG_HI = 8'h39;
    localparam logic [7:0] CH_UPP_LO = 8'h41;
    localparam logic [7:0] CH_UPP_HI = 8'h5A;
    localparam logic [7:0] CH_LOW_LO = 8'h61;
    localparam logic [7:0] CH_LOW_HI = 8'h7A;

    // label length and blank count both saturate here
    localparam logic [1:0] CNT_SAT = 2'd2;
    localparam logic [1:0] ONE_BLANK = 2'd1;

    // character classification
    typedef struct packed {
        logic is_blank;
        logic is_dot;
        logic is_dash;
        logic is_name;
    } t_char_class;

    // per-request outcome from the side tracker
    typedef struct packed {
        logic valid;
        logic seen;
    } t_result;

endpackage

### sv/nmd_char_class.sv
// classifies one message byte into blank, dot, dash and name-character flags
// depends on nmd_pkg
module nmd_char_class (
    input  logic [7:0]          i_char,
    output nmd_pkg::t_char_class o_class
);
    import nmd_pkg::*;

    logic w_digit;
    logic w_upper;
    logic w_lower;

    // range compares
    assign w_digit = (i_char >= CH_DIG_LO) && (i_char <= CH_DIG_HI);
    assign w_upper = (i_char >= CH_UPP_LO) && (i_char <= CH_UPP_HI);
    assign w_lower = (i_char >= CH_LOW_LO) && (i_char <= CH_LOW_HI);

    // flags
    always_comb begin
        o_class.is_blank = (i_char == CH_BLANK);
        o_class.is_dot   = (i_char == CH_DOT);
        o_class.is_dash  = (i_char == CH_DASH);
        o_class.is_name  = w_digit || w_upper || w_lower || (i_char == CH_DASH)
                           || (i_char == CH_DOT) || (i_char == CH_STAR);
    end

endmodule

### sv/nmd_side_tracker.sv
// running state of the two domain-name sides, updated once per accepted byte
// depends on nmd_pkg
module nmd_side_tracker (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_take,
    input  nmd_pkg::t_char_class i_class,
    input  logic                 i_final,
    output nmd_pkg::t_result     o_res
);
    import nmd_pkg::*;

    logic [1:0] r_blank_count, n_blank_count;
    logic       r_side_empty,  n_side_empty;
    logic       r_prev_punct,  n_prev_punct;
    logic [1:0] r_label_len,   n_label_len;
    logic       r_dot_seen,    n_dot_seen;
    logic       r_side_inv,    n_side_inv;
    logic       r_left_ok,     n_left_ok;
    logic       w_side_ok_cur;
    logic       w_side_ok_next;

    // current side forms a complete name
    assign w_side_ok_cur = !r_side_inv && !r_side_empty && r_dot_seen && !r_prev_punct
                           && (r_label_len == CNT_SAT);

    // next-state update for one byte
    always_comb begin
        n_blank_count = r_blank_count;
        n_side_empty  = r_side_empty;
        n_prev_punct  = r_prev_punct;
        n_label_len   = r_label_len;
        n_dot_seen    = r_dot_seen;
        n_side_inv    = r_side_inv;
        n_left_ok     = r_left_ok;
        if (i_class.is_blank) begin
            if (r_blank_count == 2'd0) begin
                n_left_ok = w_side_ok_cur;
            end
            if (r_blank_count != CNT_SAT) begin
                n_blank_count = r_blank_count + 2'd1;
            end
            n_side_empty = 1'b1;
            n_prev_punct = 1'b0;
            n_label_len  = 2'd0;
            n_dot_seen   = 1'b0;
            n_side_inv   = 1'b0;
        end else begin
            if (r_side_empty && (i_class.is_dot || i_class.is_dash)) begin
                n_side_inv = 1'b1;
            end
            priority if (!i_class.is_name) begin
                n_side_inv = 1'b1;
            end else if (i_class.is_dot) begin
                if (r_label_len == 2'd0) begin
                    n_side_inv = 1'b1;
                end
                n_label_len = 2'd0;
                n_dot_seen  = 1'b1;
            end else begin
                if (r_label_len != CNT_SAT) begin
                    n_label_len = r_label_len + 2'd1;
                end
            end
            n_side_empty = 1'b0;
            n_prev_punct = i_class.is_dot || i_class.is_dash;
        end
    end

    // verdict on the right side after this byte
    assign w_side_ok_next = !n_side_inv && !n_side_empty && n_dot_seen && !n_prev_punct
                            && (n_label_len == CNT_SAT);

    always_comb begin
        o_res.valid = i_take && i_final;
        o_res.seen  = (n_blank_count == ONE_BLANK) && n_left_ok && w_side_ok_next;
    end

    // state registers, cleared at reset and after the final byte of a message
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || (i_take && i_final)) begin
            r_blank_count <= 2'd0;
            r_side_empty  <= 1'b1;
            r_prev_punct  <= 1'b0;
            r_label_len   <= 2'd0;
            r_dot_seen    <= 1'b0;
            r_side_inv    <= 1'b0;
            r_left_ok     <= 1'b0;
        end else if (i_take) begin
            r_blank_count <= n_blank_count;
            r_side_empty  <= n_side_empty;
            r_prev_punct  <= n_prev_punct;
            r_label_len   <= n_label_len;
            r_dot_seen    <= n_dot_seen;
            r_side_inv    <= n_side_inv;
            r_left_ok     <= n_left_ok;
        end
    end

endmodule

### sv/netsplit_message_detector_core.sv
// m_tvalid rises in the cycle after the request carrying the last byte is taken
// throughput: one byte per cycle while the result side keeps m_tready high
// a byte is held off only while a result waits in the output register and is not taken
// reset: synchronous active-low i_rst_n clears the side state and the output valid
// top level of the netsplit message detector, depends on nmd_pkg, nmd_char_class,
// nmd_side_tracker and netsplit_message_detector_core_defines.svh
`include "netsplit_message_detector_core_defines.svh"

module netsplit_message_detector_core (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       s_tvalid,
    output logic       s_tready,
    input  logic [7:0] s_tdata,   // [7:0] char_code
    input  logic       s_tlast,   // final_char
    output logic       m_tvalid,
    input  logic       m_tready,
    output logic [7:0] m_tdata    // [0] netsplit_seen, [7:1] zero
);
    import nmd_pkg::*;

    t_char_class w_class;
    t_result     w_res;
    logic        w_take;
    logic        r_m_tvalid;
    logic        r_seen;

    // a byte enters whenever the output slot is free or being emptied
    assign s_tready = !r_m_tvalid || m_tready;
    assign w_take   = s_tvalid && s_tready;

    nmd_char_class u_class (
        .i_char  (s_tdata),
        .o_class (w_class)
    );

    nmd_side_tracker u_tracker (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_take  (w_take),
        .i_class (w_class),
        .i_final (s_tlast),
        .o_res   (w_res)
    );

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_m_tvalid <= 1'b0;
        end else if (s_tready) begin
            r_m_tvalid <= w_res.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_tready && w_res.valid) begin
            r_seen <= w_res.seen;
        end
    end

    assign m_tvalid = r_m_tvalid;
    assign m_tdata  = {7'd0, r_seen};

    // checks
    `NMD_ASSERT_NEXT(a_final_gives_result, s_tvalid && s_tready && s_tlast, m_tvalid)
    `NMD_ASSERT_NEXT(a_inner_no_result, s_tvalid && s_tready && !s_tlast && !m_tvalid, !m_tvalid)
    `NMD_ASSERT_NOW(a_stall_only_on_block, !s_tready, m_tvalid && !m_tready)

endmodule

### tb/tb_top.sv
// self-checking bench for netsplit_message_detector_core: byte requests in, one verdict per message out
// depends on nmd_pkg and the rtl of netsplit_message_detector_core
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import nmd_pkg::*;

    // ways of breaking an otherwise well-formed message
    typedef enum int {
        MUT_BYTE,
        MUT_DOT,
        MUT_DASH,
        MUT_STAR,
        MUT_BLANK_INS,
        MUT_DROP
    } t_mutation;

    logic       i_clk    = 1'b0;
    logic       i_rst_n  = 1'b0;
    logic       s_tvalid = 1'b0;
    logic       s_tready;
    logic [7:0] s_tdata  = 8'h00;   // [7:0] char_code
    logic       s_tlast  = 1'b0;    // final_char
    logic       m_tvalid;
    logic       m_tready = 1'b0;
    logic [7:0] m_tdata;            // [0] netsplit_seen, [7:1] zero

    // verdicts still owed by the block, oldest first
    bit         pending_verdicts[$];
    logic [7:0] msg_q[$];

    // mirror of the side tracking state
    logic [1:0] pr_blanks;
    logic       pr_empty;
    logic [7:0] pr_prev;
    logic [1:0] pr_label;
    logic       pr_dot;
    logic       pr_bad;
    logic       pr_left_ok;

    bit tx_idle = 1'b0;
    bit rx_idle = 1'b0;
    int rx_hold_request = 0;

    int errors           = 0;
    int bytes_sent       = 0;
    int msgs_sent        = 0;
    int verdicts_checked = 0;
    int verdicts_true    = 0;

    netsplit_message_detector_core uut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    // 10 ns clock
    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    task automatic report_mismatch(input string msg);
        $display("mismatch at %0t: %s", $realtime, msg);
        errors++;
    endtask

    // character classes of a domain name
    function automatic bit is_name_char(input logic [7:0] c);
        return (c >= CH_DIG_LO && c <= CH_DIG_HI) || (c >= CH_UPP_LO && c <= CH_UPP_HI) ||
               (c >= CH_LOW_LO && c <= CH_LOW_HI) ||
               c == CH_DASH || c == CH_DOT || c == CH_STAR;
    endfunction

    // current side forms a complete name
    function automatic bit side_is_domain();
        if (pr_bad || pr_empty || !pr_dot)
            return 1'b0;
        if (pr_prev == CH_DOT || pr_prev == CH_DASH)
            return 1'b0;
        return pr_label >= CNT_SAT;
    endfunction

    function automatic void clear_side();
        pr_empty = 1'b1;
        pr_prev  = 8'h00;
        pr_label = 2'd0;
        pr_dot   = 1'b0;
        pr_bad   = 1'b0;
    endfunction

    function automatic void clear_message();
        pr_blanks  = 2'd0;
        pr_left_ok = 1'b0;
        clear_side();
    endfunction

    // fold one byte into the mirrored state
    function automatic void track_char(input logic [7:0] c);
        if (c == CH_BLANK) begin
            if (pr_blanks == 2'd0)
                pr_left_ok = side_is_domain();
            if (pr_blanks < CNT_SAT)
                pr_blanks = pr_blanks + 2'd1;
            clear_side();
        end else begin
            if (pr_empty && (c == CH_DOT || c == CH_DASH))
                pr_bad = 1'b1;
            if (!is_name_char(c)) begin
                pr_bad = 1'b1;
            end else if (c == CH_DOT) begin
                if (pr_label == 2'd0)
                    pr_bad = 1'b1;
                pr_label = 2'd0;
                pr_dot   = 1'b1;
            end else if (pr_label < CNT_SAT) begin
                pr_label = pr_label + 2'd1;
            end
            pr_empty = 1'b0;
            pr_prev  = c;
        end
    endfunction

    // input side: every accepted request updates the mirror, the last one owes a verdict
    always @(posedge i_clk) begin
        if (i_rst_n && s_tvalid && s_tready) begin
            track_char(s_tdata);
            if (s_tlast) begin
                pending_verdicts.insert(pending_verdicts.size(),
                                        (pr_blanks == ONE_BLANK) && pr_left_ok &&
                                        side_is_domain());
                clear_message();
            end
        end
    end

    // output side: compare each taken verdict with the oldest one owed
    always @(posedge i_clk) begin : verdict_check
        bit want;
        if (i_rst_n && m_tvalid && m_tready) begin
            if (pending_verdicts.size() == 0) begin
                report_mismatch($sformatf("result %h with none owed", m_tdata));
            end else begin
                want = pending_verdicts.pop_front();
                verdicts_checked++;
                if (want)
                    verdicts_true++;
                if (m_tdata[0] !== want)
                    report_mismatch($sformatf("netsplit_seen %b, wanted %b", m_tdata[0], want));
                if (m_tdata[7:1] !== 7'd0)
                    report_mismatch($sformatf("padding bits %h not zero", m_tdata[7:1]));
            end
        end
    end

    // result sink: random stalls, long holds on request
    initial begin : result_sink
        int hold;
        forever begin
            if (rx_hold_request != 0) begin
                hold = rx_hold_request;
                rx_hold_request = 0;
                m_tready <= 1'b0;
                repeat (hold) @(posedge i_clk);
            end else if (rx_idle && $urandom_range(0, 4) == 0) begin
                m_tready <= 1'b0;
                repeat ($urandom_range(1, 6)) @(posedge i_clk);
            end else begin
                m_tready <= 1'b1;
                @(posedge i_clk);
            end
        end
    end

    // offer one byte, after a random gap now and then when tx_idle is set, and wait until the block takes it
    task automatic send_char(input logic [7:0] c, input logic last);
        if (tx_idle && $urandom_range(0, 4) == 0) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge i_clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= c;
        s_tlast  <= last;
        @(posedge i_clk);
        while (!s_tready)
            @(posedge i_clk);
        bytes_sent++;
    endtask

    task automatic send_message();
        foreach (msg_q[i])
            send_char(msg_q[i], i == msg_q.size() - 1);
        msgs_sent++;
    endtask

    task automatic wait_drained();
        @(posedge i_clk);
        while (pending_verdicts.size() != 0)
            @(posedge i_clk);
    endtask

    // add one byte at the end of the message being built
    function automatic void append_char(input logic [7:0] c);
        msg_q.insert(msg_q.size(), c);
    endfunction

    function automatic void load_text(input string text);
        msg_q.delete();
        for (int i = 0; i < text.len(); i++)
            append_char(text[i]);
    endfunction

    // mostly letters and digits, some dashes and stars
    function automatic logic [7:0] pick_name_char();
        int r;
        r = $urandom_range(0, 19);
        if (r < 10)
            return CH_LOW_LO + 8'($urandom_range(0, 25));
        else if (r < 14)
            return CH_UPP_LO + 8'($urandom_range(0, 25));
        else if (r < 17)
            return CH_DIG_LO + 8'($urandom_range(0, 9));
        else if (r < 19)
            return CH_DASH;
        return CH_STAR;
    endfunction

    // one to three labels, mostly with a dot, label lengths 1 to 3
    function automatic void add_domain();
        int labels;
        int len;
        labels = ($urandom_range(0, 7) == 0) ? 1 : $urandom_range(2, 3);
        for (int l = 0; l < labels; l++) begin
            if (l > 0)
                append_char(CH_DOT);
            len = $urandom_range(1, 3);
            repeat (len) append_char(pick_name_char());
        end
    endfunction

    function automatic void build_wellformed();
        msg_q.delete();
        add_domain();
        append_char(CH_BLANK);
        add_domain();
    endfunction

    // damage one position of the message
    function automatic void mutate_message();
        t_mutation kind;
        int pos;
        kind = t_mutation'($urandom_range(0, 5));
        pos  = $urandom_range(0, msg_q.size() - 1);
        case (kind)
            MUT_BYTE:      msg_q[pos] = 8'($urandom_range(0, 255));
            MUT_DOT:       msg_q[pos] = CH_DOT;
            MUT_DASH:      msg_q[pos] = CH_DASH;
            MUT_STAR:      msg_q[pos] = CH_STAR;
            MUT_BLANK_INS: msg_q.insert(pos, CH_BLANK);
            MUT_DROP: begin
                if (msg_q.size() > 1)
                    msg_q.delete(pos);
            end
            default:       msg_q[pos] = CH_BLANK;
        endcase
    endfunction

    // well-formed, damaged, or raw noise over the whole byte range
    function automatic void build_random_message();
        int r;
        int len;
        r = $urandom_range(0, 9);
        if (r < 8) begin
            build_wellformed();
            if (r >= 6)
                mutate_message();
        end else begin
            msg_q.delete();
            len = $urandom_range(1, 8);
            repeat (len) begin
                if ($urandom_range(0, 5) == 0)
                    append_char(CH_BLANK);
                else
                    append_char(8'($urandom_range(0, 255)));
            end
        end
    endfunction

    // edges of the byte range and the blank placements
    task automatic test_directed();
        tx_idle = 1'b0;
        rx_idle = 1'b0;
        load_text("a-*.bc d.ef");
        send_message();
        load_text(" ");
        send_message();
        load_text("k.lm ");
        send_message();
        load_text(" a.b");
        send_message();
        load_text("a  b");
        send_message();
        msg_q = '{8'h00};
        send_message();
        msg_q = '{8'hFF};
        send_message();
    endtask

    task automatic test_random_traffic();
        tx_idle = 1'b1;
        rx_idle = 1'b1;
        while (bytes_sent < 430) begin
            build_random_message();
            send_message();
        end
    endtask

    // sink holds off while requests keep coming, so the input stalls
    task automatic test_result_backpressure();
        tx_idle = 1'b0;
        rx_idle = 1'b0;
        rx_hold_request = 200;
        repeat (5) begin
            build_wellformed();
            send_message();
        end
        s_tvalid <= 1'b0;
        wait_drained();
    endtask

    // sender waits for every verdict before the next message
    task automatic test_drain_pause();
        tx_idle = 1'b1;
        rx_idle = 1'b1;
        repeat (5) begin
            build_random_message();
            send_message();
            s_tvalid <= 1'b0;
            wait_drained();
        end
    endtask

    // back to back requests with a sink that never stalls
    task automatic test_steady_stream();
        tx_idle = 1'b0;
        rx_idle = 1'b0;
        while (bytes_sent < 580) begin
            build_random_message();
            send_message();
        end
        s_tvalid <= 1'b0;
    endtask

    // main sequence
    initial begin : main_seq
        int guard;
        clear_message();
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        test_directed();
        test_random_traffic();
        test_result_backpressure();
        test_drain_pause();
        test_steady_stream();
        guard = 0;
        while (pending_verdicts.size() != 0 && guard < 10000) begin
            @(posedge i_clk);
            guard++;
        end
        if (pending_verdicts.size() != 0) begin
            $display("timeout with %0d verdicts still owed", pending_verdicts.size());
            $display("simulation failed");
            $finish;
        end else begin
            repeat (10) @(posedge i_clk);
            $display("covered %0d bytes in %0d messages, %0d verdicts checked, %0d of them true",
                     bytes_sent, msgs_sent, verdicts_checked, verdicts_true);
            $display("stalls on both sides, a long sink hold and drained pauses, %0d mismatches",
                     errors);
            if (errors == 0)
                $display("simulation ok");
            else
                $display("simulation failed");
            $finish;
        end
    end

    // watchdog
    initial begin
        #1000000;
        $display("watchdog expired");
        $display("simulation failed");
        $finish;
    end

endmodule

### files.f
+incdir+sv
sv/nmd_pkg.sv
sv/nmd_char_class.sv
sv/nmd_side_tracker.sv
sv/netsplit_message_detector_core.sv
tb/tb_top.sv
